@@ rtl/core/configurable_crc_engine_macros.svh @@
// Assertion helpers. Each expects clk and rst_n in the enclosing module.
`ifndef CONFIGURABLE_CRC_ENGINE_MACROS_SVH
`define CONFIGURABLE_CRC_ENGINE_MACROS_SVH

`define CRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/crc_pkg.sv @@
package crc_pkg;

  localparam int CRC_BITS          = 64;
  localparam int BYTE_BITS         = 8;
  localparam int WIDTH_BITS        = 7;
  localparam int CFG_IDX_BITS      = 3;
  localparam int MIN_CRC_WIDTH     = 8;
  localparam int MAX_CRC_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic [CRC_BITS-1:0]   POLY_RST  = CRC_BITS'(7);
  localparam logic [WIDTH_BITS-1:0] WIDTH_RST = WIDTH_BITS'(8);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POLY   = 3'd0,
    REG_INIT   = 3'd1,
    REG_XOROUT = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_REFIN  = 3'd4,
    REG_REFOUT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CRC_BITS-1:0]   poly;
    logic [CRC_BITS-1:0]   init;
    logic [CRC_BITS-1:0]   xorout;
    logic [WIDTH_BITS-1:0] width;
    logic                  refin;
    logic                  refout;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 has;
    logic                 first;
    logic                 last;
  } op_t;

endpackage

@@ rtl/core/crc_front.sv @@
module crc_front import crc_pkg::*; (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_BITS-1:0] in_data_byte,
  input  logic                 in_has_byte,
  input  logic                 in_first_byte,
  input  logic                 in_last_byte,
  input  logic                 refin,
  input  logic                 q_ready,
  output logic                 q_push,
  output op_t                  q_op
);

  logic [BYTE_BITS-1:0] rev_byte;

  always_comb begin
    for (int i = 0; i < BYTE_BITS; i++) begin
      rev_byte[i] = in_data_byte[BYTE_BITS-1-i];
    end
  end

  // every item goes through: even an empty one re-masks the remainder to the width
  assign in_stall   = !q_ready;
  assign q_push     = in_valid && q_ready;
  assign q_op.data  = refin ? rev_byte : in_data_byte;
  assign q_op.has   = in_has_byte;
  assign q_op.first = in_first_byte;
  assign q_op.last  = in_last_byte;

endmodule

@@ rtl/core/crc_fifo.sv @@
`include "configurable_crc_engine_macros.svh"

module crc_fifo import crc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  wr_op,
  output logic ready,
  input  logic pop,
  output logic valid,
  output op_t  rd_op
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  op_t            mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign ready = (count_r != FULL_CNT);
  assign valid = (count_r != '0);
  assign rd_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  `CRC_ASSERT_ALWAYS(a_count_bound, count_r <= FULL_CNT, "queue count beyond depth")
  `CRC_ASSERT_ALWAYS(a_no_underflow, !(pop && (count_r == '0)), "pop from empty queue")

endmodule

@@ rtl/core/crc_back.sv @@
`include "configurable_crc_engine_macros.svh"

module crc_back import crc_pkg::*; #(
  parameter int MAX_CRC_WIDTH = MAX_CRC_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                q_valid,
  input  op_t                 q_op,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CRC_BITS-1:0] out_crc_value
);

  localparam int W = MAX_CRC_WIDTH;
  localparam logic [WIDTH_BITS-1:0] W_TOP = WIDTH_BITS'(W);
  localparam logic [WIDTH_BITS-1:0] W_MIN = WIDTH_BITS'(MIN_CRC_WIDTH);

  logic [W-1:0]          rem_r, rem_nxt;
  logic [W-1:0]          res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WIDTH_BITS-1:0] eff_w, sh;
  logic [W-1:0]          poly_al, base_al, fx_al, upd_al, res_al, res_rev;
  logic                  slot_free;

  // work left-aligned: the CRC's top bit is always bit W-1, low bits shift in zero
  always_comb begin
    if (cfg.width < W_MIN) begin
      eff_w = W_MIN;
    end else if (cfg.width > W_TOP) begin
      eff_w = W_TOP;
    end else begin
      eff_w = cfg.width;
    end
    sh      = W_TOP - eff_w;
    poly_al = cfg.poly[W-1:0] << sh;
    fx_al   = cfg.xorout[W-1:0] << sh;
    base_al = (q_op.first ? cfg.init[W-1:0] : rem_r) << sh;
  end

  always_comb begin
    upd_al = base_al;
    if (q_op.has) begin
      upd_al = upd_al ^ (W'(q_op.data) << (W - BYTE_BITS));
      for (int i = 0; i < BYTE_BITS; i++) begin
        upd_al = {upd_al[W-2:0], 1'b0} ^ (upd_al[W-1] ? poly_al : '0);
      end
    end
  end

  always_comb begin
    res_al = upd_al ^ fx_al;
    for (int i = 0; i < W; i++) begin
      res_rev[i] = res_al[W-1-i];
    end
    res_nxt = cfg.refout ? res_rev : (res_al >> sh);
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!q_op.last || slot_free);
  assign rem_nxt   = q_pop ? (upd_al >> sh) : rem_r;

  always_comb begin
    if (q_pop && q_op.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.last) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = CRC_BITS'(res_r);

  `CRC_ASSERT_NEXT(a_last_emits, q_pop && q_op.last, out_valid_r, "last item gave no result")
  `CRC_ASSERT_NEXT(a_held_result, out_valid_r && out_stall, out_valid_r, "stalled result lost")

endmodule

@@ rtl/core/configurable_crc_engine.sv @@
// A result is presented once its last item is accepted and has passed through the queue
// and then the output register.
// Throughput: one item per cycle unless out_stall holds a finished result; set by the
// remainder register loop, which folds a whole byte (eight polynomial steps) per cycle.
// Queue (two entries by default) between the front and the CRC back end; results sit in an output register.
// Reset (rst_n low, synchronous): remainder 0, queue and result empty,
// registers to polynomial 7, width 8, others 0.
module configurable_crc_engine import crc_pkg::*; #(
  parameter int MAX_CRC_WIDTH = MAX_CRC_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_BITS-1:0]    in_data_byte,
  input  logic                    in_has_byte,
  input  logic                    in_first_byte,
  input  logic                    in_last_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CRC_BITS-1:0]     out_crc_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CRC_BITS-1:0]     cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_ready, q_valid, q_pop;
  op_t  q_wr_op, q_rd_op;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_POLY:   cfg_nxt.poly   = cfg_wdata;
        REG_INIT:   cfg_nxt.init   = cfg_wdata;
        REG_XOROUT: cfg_nxt.xorout = cfg_wdata;
        REG_WIDTH:  cfg_nxt.width  = cfg_wdata[WIDTH_BITS-1:0];
        REG_REFIN:  cfg_nxt.refin  = cfg_wdata[0];
        REG_REFOUT: cfg_nxt.refout = cfg_wdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly   <= POLY_RST;
      cfg_r.init   <= '0;
      cfg_r.xorout <= '0;
      cfg_r.width  <= WIDTH_RST;
      cfg_r.refin  <= 1'b0;
      cfg_r.refout <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_has_byte   (in_has_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .refin         (cfg_r.refin),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_op          (q_wr_op)
  );

  crc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_op (q_wr_op),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rd_op (q_rd_op)
  );

  crc_back #(
    .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_op          (q_rd_op),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

endmodule
